@@ rtl/core/io_direct_cache_access_engine_defines.svh @@
// Assertion helpers used by the engine top level.
`ifndef IO_DIRECT_CACHE_ACCESS_ENGINE_DEFINES_SVH
`define IO_DIRECT_CACHE_ACCESS_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define DCAE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define DCAE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/dcae_pkg.sv @@
package dcae_pkg;

	localparam int LINE_BYTES = 8;
	localparam int OFF_W      = $clog2(LINE_BYTES);
	localparam int ADDR_W     = 48;
	localparam int DATA_W     = 64;
	localparam int SIZE_W     = 4;
	localparam int CLIENT_W   = 6;
	localparam int CNT_W      = 8;
	localparam int CMD_W      = 3;
	localparam int KIND_W     = 3;
	localparam int ERR_W      = 2;
	localparam int MASK_W     = LINE_BYTES;
	localparam int S_TDATA_W  = 128;
	localparam int M_TDATA_W  = 136;

	// request / completion commands
	localparam logic [CMD_W-1:0] CMD_RD_REQ  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_WR_REQ  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_FL_REQ  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RD_DONE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_WR_DONE = 3'd4;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_MEM_RD = 3'd0;
	localparam logic [KIND_W-1:0] KIND_MEM_WR = 3'd1;
	localparam logic [KIND_W-1:0] KIND_RD_RSP = 3'd2;
	localparam logic [KIND_W-1:0] KIND_FL_ACK = 3'd3;
	localparam logic [KIND_W-1:0] KIND_BUSY   = 3'd4;
	localparam logic [KIND_W-1:0] KIND_ERROR  = 3'd5;

	// error codes
	localparam logic [ERR_W-1:0] ERR_CROSS = 2'd0;
	localparam logic [ERR_W-1:0] ERR_SIZE  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_PERM  = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [CLIENT_W-1:0] client;
		logic [ADDR_W-1:0]   address;
		logic [SIZE_W-1:0]   size;
		logic [DATA_W-1:0]   data;
		logic                permission_ok;
	} req_t;

	// One queued result; data and mask are shaped in the back end.
	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [ERR_W-1:0]    error_code;
		logic [CLIENT_W-1:0] dest;
		logic [ADDR_W-1:0]   address;
		logic [SIZE_W-1:0]   len;
		logic [DATA_W-1:0]   data;
		logic [SIZE_W-1:0]   shift;
	} entry_t;

	typedef struct packed {
		logic             read_outstanding;
		logic             flush_active;
		logic [CNT_W-1:0] pending_writes;
	} status_t;

	function automatic logic [DATA_W-1:0] low_bytes(input logic [SIZE_W-1:0] n);
		logic [DATA_W-1:0] r;
		r = '0;
		for (int i = 0; i < DATA_W / 8; i++) begin
			r[i*8 +: 8] = (SIZE_W'(i) < n) ? 8'hFF : 8'h00;
		end
		return r;
	endfunction

endpackage

@@ rtl/core/dcae_front.sv @@
module dcae_front #(
	parameter int MAX_PENDING_WRITES = 255
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               q_ready,
	input  dcae_pkg::req_t     req,
	output logic               push,
	output dcae_pkg::entry_t   push_entry,
	output dcae_pkg::status_t  stat
);
	import dcae_pkg::*;

	logic                read_out_q, read_out_d;
	logic                flush_q, flush_d;
	logic [CNT_W-1:0]    pend_q, pend_d;
	logic [CLIENT_W-1:0] wclient_q, wclient_d;
	logic [ADDR_W-1:0]   waddr_q, waddr_d;
	logic [SIZE_W-1:0]   wsize_q, wsize_d;

	logic                accept, has_result;
	logic [OFF_W-1:0]    offset;
	logic [ADDR_W-1:0]   line;
	logic                is_req, size_big, crosses, cover_miss;
	logic [OFF_W+1:0]    end_off;
	logic [ADDR_W-1:0]   skip;
	entry_t              e;

	assign accept = in_valid && q_ready;
	assign offset = req.address[OFF_W-1:0];
	assign line   = {req.address[ADDR_W-1:OFF_W], {OFF_W{1'b0}}};
	assign end_off = (OFF_W+2)'(offset) + (OFF_W+2)'(req.size);
	assign is_req   = (req.cmd == CMD_RD_REQ) || (req.cmd == CMD_WR_REQ) ||
		(req.cmd == CMD_FL_REQ);
	assign size_big = req.size > SIZE_W'(LINE_BYTES);
	assign crosses  = end_off > (OFF_W+2)'(LINE_BYTES);
	// completion line must start at or below the waiting range and reach its end
	assign cover_miss = (req.address > waddr_q) ||
		(({1'b0, req.address} + (ADDR_W+1)'(LINE_BYTES)) <
		({1'b0, waddr_q} + (ADDR_W+1)'(wsize_q)));
	assign skip = waddr_q - req.address;

	always_comb begin
		e          = '0;
		has_result = 1'b0;
		read_out_d = read_out_q;
		flush_d    = flush_q;
		pend_d     = pend_q;
		wclient_d  = wclient_q;
		waddr_d    = waddr_q;
		wsize_d    = wsize_q;
		if (is_req && size_big) begin
			has_result   = 1'b1;
			e.kind       = KIND_ERROR;
			e.error_code = ERR_SIZE;
			e.dest       = req.client;
		end else if (is_req && crosses) begin
			has_result   = 1'b1;
			e.kind       = KIND_ERROR;
			e.error_code = ERR_CROSS;
			e.dest       = req.client;
		end else if ((req.cmd == CMD_RD_REQ || req.cmd == CMD_WR_REQ) && !req.permission_ok) begin
			has_result   = 1'b1;
			e.kind       = KIND_ERROR;
			e.error_code = ERR_PERM;
			e.dest       = req.client;
		end else begin
			unique case (req.cmd)
				CMD_RD_REQ: begin
					has_result = 1'b1;
					if (read_out_q || flush_q) begin
						e.kind = KIND_BUSY;
						e.dest = req.client;
					end else begin
						e.kind     = KIND_MEM_RD;
						e.address  = line;
						read_out_d = 1'b1;
						wclient_d  = req.client;
						waddr_d    = req.address;
						wsize_d    = req.size;
					end
				end
				CMD_WR_REQ: begin
					has_result = 1'b1;
					if (pend_q >= CNT_W'(MAX_PENDING_WRITES)) begin
						e.kind = KIND_BUSY;
						e.dest = req.client;
					end else begin
						e.kind    = KIND_MEM_WR;
						e.address = line;
						e.len     = req.size;
						e.data    = req.data;
						e.shift   = SIZE_W'(offset);
						pend_d    = pend_q + 1'b1;
					end
				end
				CMD_FL_REQ: begin
					if (read_out_q || flush_q) begin
						has_result = 1'b1;
						e.kind     = KIND_BUSY;
						e.dest     = req.client;
					end else if (pend_q == '0) begin
						has_result = 1'b1;
						e.kind     = KIND_FL_ACK;
						e.dest     = req.client;
					end else begin
						flush_d   = 1'b1;
						wclient_d = req.client;
					end
				end
				CMD_RD_DONE: begin
					if (read_out_q && !cover_miss) begin
						has_result = 1'b1;
						e.kind     = KIND_RD_RSP;
						e.dest     = wclient_q;
						e.address  = waddr_q;
						e.len      = wsize_q;
						e.data     = req.data;
						e.shift    = skip[SIZE_W-1:0];
						read_out_d = 1'b0;
					end
				end
				CMD_WR_DONE: begin
					if (pend_q != '0) begin
						pend_d = pend_q - 1'b1;
						if (pend_q == CNT_W'(1) && flush_q) begin
							flush_d    = 1'b0;
							has_result = 1'b1;
							e.kind     = KIND_FL_ACK;
							e.dest     = wclient_q;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign push       = accept && has_result;
	assign push_entry = e;
	assign stat       = '{read_outstanding: read_out_q, flush_active: flush_q,
		pending_writes: pend_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_out_q <= 1'b0;
			flush_q    <= 1'b0;
			pend_q     <= '0;
			wclient_q  <= '0;
			waddr_q    <= '0;
			wsize_q    <= '0;
		end else if (accept) begin
			read_out_q <= read_out_d;
			flush_q    <= flush_d;
			pend_q     <= pend_d;
			wclient_q  <= wclient_d;
			waddr_q    <= waddr_d;
			wsize_q    <= wsize_d;
		end
	end

endmodule

@@ rtl/core/dcae_queue.sv @@
module dcae_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dcae_pkg::entry_t  push_entry,
	input  logic              pop,
	output logic              ready,
	output logic              head_valid,
	output dcae_pkg::entry_t  head
);
	import dcae_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t         mem_q [DEPTH];
	logic [AW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  cnt_q;
	logic           do_pop;

	assign ready      = cnt_q != CW'(DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/dcae_back.sv @@
module dcae_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            head_valid,
	input  dcae_pkg::entry_t                head,
	output logic                            pop,
	input  logic                            m_tready,
	output logic                            m_tvalid,
	output logic [dcae_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic [dcae_pkg::KIND_W-1:0]     m_tuser
);
	import dcae_pkg::*;

	logic                valid_q;
	logic [KIND_W-1:0]   kind_q;
	logic [ERR_W-1:0]    err_q;
	logic [CLIENT_W-1:0] dest_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [SIZE_W-1:0]   size_q;
	logic [DATA_W-1:0]   data_q;
	logic [MASK_W-1:0]   mask_q;

	logic [DATA_W-1:0]   data_c;
	logic [MASK_W-1:0]   mask_c;
	logic [SIZE_W-1:0]   size_c;
	logic [MASK_W:0]     len_ones;
	logic [2*MASK_W-1:0] mask_w;
	logic [SIZE_W+2:0]   bit_shift;

	assign pop       = head_valid && (!valid_q || m_tready);
	assign len_ones  = ((MASK_W+1)'(1) << head.len) - (MASK_W+1)'(1);
	assign mask_w    = (2*MASK_W)'(len_ones) << head.shift;
	assign bit_shift = {head.shift, 3'b000};

	// place write bytes at their line offset, or pull read bytes down to bit 0
	always_comb begin
		data_c = '0;
		mask_c = '0;
		size_c = '0;
		unique case (head.kind)
			KIND_MEM_WR: begin
				data_c = (head.data & low_bytes(head.len)) << bit_shift;
				mask_c = mask_w[MASK_W-1:0];
				size_c = SIZE_W'(LINE_BYTES);
			end
			KIND_MEM_RD: begin
				size_c = SIZE_W'(LINE_BYTES);
			end
			KIND_RD_RSP: begin
				data_c = (head.data >> bit_shift) & low_bytes(head.len);
				size_c = head.len;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || m_tready) begin
			valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= head.kind;
			err_q  <= head.error_code;
			dest_q <= head.dest;
			addr_q <= head.address;
			size_q <= size_c;
			data_q <= data_c;
			mask_q <= mask_c;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = {{(M_TDATA_W - ERR_W - CLIENT_W - ADDR_W - SIZE_W - DATA_W - MASK_W){1'b0}},
		mask_q, data_q, size_q, addr_q, dest_q, err_q};

endmodule

@@ rtl/core/io_direct_cache_access_engine.sv @@
// Throughput: one word per cycle on both sides while the queue has room and m_tready is high.
// The front decides and updates state in the cycle of acceptance; the result queue and the
// output register, which a result passes through in that order, decouple the sides.
// s_tready drops only while the result queue is full.
// Reset (arst_n low, asynchronous) clears the read slot, flush flag, write count and queue.
`include "io_direct_cache_access_engine_defines.svh"

module io_direct_cache_access_engine #(
	parameter int MAX_PENDING_WRITES = 255,
	parameter int QUEUE_DEPTH        = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// client[5:0], address[53:6], size[57:54], data[121:58], permission_ok[122]
	input  logic [dcae_pkg::S_TDATA_W-1:0]  s_tdata,
	// cmd[2:0]
	input  logic [dcae_pkg::CMD_W-1:0]      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// error_code[1:0], dest_client[7:2], out_address[55:8], out_size[59:56],
	// out_data[123:60], byte_mask[131:124]
	output logic [dcae_pkg::M_TDATA_W-1:0]  m_tdata,
	// kind[2:0]
	output logic [dcae_pkg::KIND_W-1:0]     m_tuser
);
	import dcae_pkg::*;

	req_t    req;
	entry_t  push_entry, head;
	status_t stat;
	logic    push, q_ready, head_valid, pop;

	// unpack the request word, lowest field first
	assign req.cmd           = s_tuser;
	assign req.client        = s_tdata[5:0];
	assign req.address       = s_tdata[53:6];
	assign req.size          = s_tdata[57:54];
	assign req.data          = s_tdata[121:58];
	assign req.permission_ok = s_tdata[122];

	assign s_tready = q_ready;

	// front: checks, busy decisions and engine state
	dcae_front #(
		.MAX_PENDING_WRITES(MAX_PENDING_WRITES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.q_ready   (q_ready),
		.req       (req),
		.push      (push),
		.push_entry(push_entry),
		.stat      (stat)
	);

	// hold decided results until the master side takes them
	dcae_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.ready     (q_ready),
		.head_valid(head_valid),
		.head      (head)
	);

	// back: shape data and byte mask, drive the output register
	dcae_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	`DCAE_ASSERT_NEXT(a_rd_claims_slot, push && push_entry.kind == KIND_MEM_RD, stat.read_outstanding, "memory read issued without claiming the read slot")
	`DCAE_ASSERT_NEXT(a_rsp_frees_slot, push && push_entry.kind == KIND_RD_RSP, !stat.read_outstanding, "read response left the read slot held")
	`DCAE_ASSERT_IMP(a_flush_needs_writes, stat.flush_active, stat.pending_writes != '0, "flush active with no pending writes")
	`DCAE_ASSERT_IMP(a_busy_err_bare, m_tvalid && (m_tuser == KIND_BUSY || m_tuser == KIND_ERROR), m_tdata[131:8] == '0, "busy or error word carries payload")

endmodule

@@ tb/io_direct_cache_access_engine_tb.sv @@
module io_direct_cache_access_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dcae_pkg::*;

	localparam int WR_LIMIT = 255;
	localparam logic [CMD_W-1:0] CMD_TOP = {CMD_W{1'b1}};

	// one request or completion word, as the bus presents it
	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [CLIENT_W-1:0] client;
		logic [ADDR_W-1:0]   addr;
		logic [SIZE_W-1:0]   size;
		logic [DATA_W-1:0]   data;
		logic                perm;
	} bus_word_t;

	// one engine output word, unpacked from tuser/tdata
	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [ERR_W-1:0]    err;
		logic [CLIENT_W-1:0] dest;
		logic [ADDR_W-1:0]   addr;
		logic [SIZE_W-1:0]   len;
		logic [DATA_W-1:0]   data;
		logic [MASK_W-1:0]   mask;
	} eng_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [CMD_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [KIND_W-1:0] m_tuser;

	// shadow of the engine state, advanced on every accepted word
	logic rd_busy;
	logic [CLIENT_W-1:0] wait_client;
	logic [ADDR_W-1:0] wait_addr;
	logic [SIZE_W-1:0] wait_size;
	int wr_pending;
	logic fl_on;

	eng_word_t owed_words[$];
	int unsigned mismatches = 0;
	bit gaps_on = 1'b1;
	int hold_left = 0;
	int rx_gap = 0;

	always #5 clk = ~clk;

	io_direct_cache_access_engine #(
		.MAX_PENDING_WRITES(WR_LIMIT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// all-ones in the low n bytes
	function automatic logic [DATA_W-1:0] byte_fill(input logic [SIZE_W-1:0] n);
		if (n >= 8) begin
			return '1;
		end
		return (64'd1 << (8 * n)) - 64'd1;
	endfunction

	function automatic eng_word_t busy_for(input logic [CLIENT_W-1:0] client);
		eng_word_t r;
		r = '0;
		r.kind = KIND_BUSY;
		r.dest = client;
		return r;
	endfunction

	// Advance the shadow state by one word; return 1 with the output word if one is due.
	function automatic bit engine_step(input bus_word_t w, output eng_word_t r);
		logic [63:0] off;
		logic [63:0] line;
		logic [63:0] skip;
		logic [63:0] val;
		logic [63:0] mask64;
		r = '0;
		off = 64'(w.addr) % 64'(LINE_BYTES);
		line = 64'(w.addr) - off;
		if (w.cmd <= CMD_FL_REQ) begin
			r.kind = KIND_ERROR;
			r.dest = w.client;
			if (w.size > LINE_BYTES) begin
				r.err = ERR_SIZE;
				return 1'b1;
			end
			if (off + w.size > LINE_BYTES) begin
				r.err = ERR_CROSS;
				return 1'b1;
			end
			if (w.cmd != CMD_FL_REQ && !w.perm) begin
				r.err = ERR_PERM;
				return 1'b1;
			end
			r = '0;
		end
		case (w.cmd)
			CMD_RD_REQ: begin
				if (rd_busy || fl_on) begin
					r = busy_for(w.client);
					return 1'b1;
				end
				rd_busy = 1'b1;
				wait_client = w.client;
				wait_addr = w.addr;
				wait_size = w.size;
				r.kind = KIND_MEM_RD;
				r.addr = line[ADDR_W-1:0];
				r.len = SIZE_W'(LINE_BYTES);
				return 1'b1;
			end
			CMD_WR_REQ: begin
				if (wr_pending >= WR_LIMIT) begin
					r = busy_for(w.client);
					return 1'b1;
				end
				wr_pending++;
				r.kind = KIND_MEM_WR;
				r.addr = line[ADDR_W-1:0];
				r.len = SIZE_W'(LINE_BYTES);
				r.data = (w.data & byte_fill(w.size)) << (8 * off);
				mask64 = ((64'd1 << w.size) - 64'd1) << off;
				r.mask = mask64[MASK_W-1:0];
				return 1'b1;
			end
			CMD_FL_REQ: begin
				if (rd_busy || fl_on) begin
					r = busy_for(w.client);
					return 1'b1;
				end
				if (wr_pending == 0) begin
					r.kind = KIND_FL_ACK;
					r.dest = w.client;
					return 1'b1;
				end
				fl_on = 1'b1;
				wait_client = w.client;
				return 1'b0;
			end
			CMD_RD_DONE: begin
				if (!rd_busy) begin
					return 1'b0;
				end
				if (w.addr > wait_addr ||
						64'(w.addr) + LINE_BYTES < 64'(wait_addr) + wait_size) begin
					return 1'b0;
				end
				skip = 64'(wait_addr) - 64'(w.addr);
				val = (skip >= 8) ? 64'd0 : (w.data >> (8 * skip));
				rd_busy = 1'b0;
				r.kind = KIND_RD_RSP;
				r.dest = wait_client;
				r.addr = wait_addr;
				r.len = wait_size;
				r.data = val & byte_fill(wait_size);
				return 1'b1;
			end
			CMD_WR_DONE: begin
				if (wr_pending == 0) begin
					return 1'b0;
				end
				wr_pending--;
				if (wr_pending == 0 && fl_on) begin
					fl_on = 1'b0;
					r.kind = KIND_FL_ACK;
					r.dest = wait_client;
					return 1'b1;
				end
				return 1'b0;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic bus_word_t mk(input logic [CMD_W-1:0] cmd, input logic [CLIENT_W-1:0] client,
			input logic [ADDR_W-1:0] addr, input logic [SIZE_W-1:0] size,
			input logic [DATA_W-1:0] data, input logic perm);
		bus_word_t w;
		w.cmd = cmd;
		w.client = client;
		w.addr = addr;
		w.size = size;
		w.data = data;
		w.perm = perm;
		return w;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (!gaps_on) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [ADDR_W-1:0] rand_addr();
		logic [63:0] a;
		case ($urandom_range(0, 9))
			0: a = 64'($urandom_range(0, 15));
			1: a = {16'h0, {ADDR_W{1'b1}}} - 64'($urandom_range(0, 15));
			default: a = {$urandom, $urandom};
		endcase
		return a[ADDR_W-1:0];
	endfunction

	// Mostly well-formed traffic that tracks the shadow state, plus some noise.
	function automatic bus_word_t rand_word();
		bus_word_t w;
		int pick;
		logic [63:0] lo;
		w.client = CLIENT_W'($urandom_range(0, 63));
		w.addr = rand_addr();
		w.data = {$urandom, $urandom};
		w.perm = ($urandom_range(0, 9) != 0);
		w.size = SIZE_W'($urandom_range(0, LINE_BYTES - int'(w.addr % LINE_BYTES)));
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			w.cmd = CMD_RD_REQ;
		end else if (pick < 45) begin
			w.cmd = CMD_WR_REQ;
		end else if (pick < 52) begin
			w.cmd = CMD_FL_REQ;
		end else if (pick < 72) begin
			w.cmd = CMD_RD_DONE;
			// aim a completion at a line that covers the waiting range
			if (rd_busy && $urandom_range(0, 4) != 0) begin
				lo = (64'(wait_addr) + wait_size >= LINE_BYTES) ?
					64'(wait_addr) + wait_size - LINE_BYTES : 64'd0;
				lo = lo + 64'($urandom_range(0, int'(64'(wait_addr) - lo)));
				w.addr = lo[ADDR_W-1:0];
			end
		end else if (pick < 92) begin
			w.cmd = CMD_WR_DONE;
		end else if (pick < 96) begin
			w.cmd = CMD_W'($urandom_range(CMD_WR_DONE + 1, CMD_TOP));
		end else begin
			w.cmd = CMD_W'($urandom_range(0, CMD_TOP));
			w.size = SIZE_W'($urandom_range(0, 15));
			w.perm = 1'($urandom_range(0, 1));
		end
		return w;
	endfunction

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 50) begin
			$display("%0t ns: mismatch: %s", $time, msg);
		end
	endtask

	// Offer one word, hold it until accepted, then book the output it owes.
	task automatic send_word(input bus_word_t w);
		int gap;
		eng_word_t r;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, w.perm, w.data, w.size, w.addr, w.client};
		s_tuser <= w.cmd;
		do @(posedge clk); while (!s_tready);
		if (engine_step(w, r)) begin
			owed_words.push_back(r);
		end
	endtask

	// Stop offering until every owed output word is back, then let the pipe settle.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (owed_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_word();
		eng_word_t got;
		eng_word_t want;
		got.kind = m_tuser;
		got.err = m_tdata[1:0];
		got.dest = m_tdata[7:2];
		got.addr = m_tdata[55:8];
		got.len = m_tdata[59:56];
		got.data = m_tdata[123:60];
		got.mask = m_tdata[131:124];
		if (owed_words.size() == 0) begin
			note_mismatch($sformatf("output word with nothing owed, kind %0d", got.kind));
			return;
		end
		want = owed_words.pop_front();
		if (got.kind !== want.kind)
			note_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
		if (got.err !== want.err)
			note_mismatch($sformatf("error_code %0d, want %0d", got.err, want.err));
		if (got.dest !== want.dest)
			note_mismatch($sformatf("dest_client %0d, want %0d", got.dest, want.dest));
		if (got.addr !== want.addr)
			note_mismatch($sformatf("out_address %h, want %h", got.addr, want.addr));
		if (got.len !== want.len)
			note_mismatch($sformatf("out_size %0d, want %0d", got.len, want.len));
		if (got.data !== want.data)
			note_mismatch($sformatf("out_data %h, want %h", got.data, want.data));
		if (got.mask !== want.mask)
			note_mismatch($sformatf("byte_mask %h, want %h", got.mask, want.mask));
	endtask

	// Output side: check each accepted word, then pick the next ready level.
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				check_word();
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				rx_gap = pick_gap();
			end
		end
	end

	// Extremes, every command, every error and the busy, flush and completion corners.
	task automatic test_directed();
		send_word(mk(CMD_RD_REQ, 6'd63, 48'hFFFF_FFFF_FFF8, 4'd8, '0, 1'b1));
		send_word(mk(CMD_RD_REQ, 6'd0, 48'h0, 4'd1, '0, 1'b1));
		send_word(mk(CMD_FL_REQ, 6'd1, 48'h0, 4'd0, '0, 1'b1));
		// completion above the waiting address: ignored
		send_word(mk(CMD_RD_DONE, 6'd0, 48'hFFFF_FFFF_FFF9, 4'd0, '1, 1'b1));
		send_word(mk(CMD_RD_DONE, 6'd0, 48'hFFFF_FFFF_FFF8, 4'd0,
			64'h0123_4567_89AB_CDEF, 1'b1));
		send_word(mk(CMD_RD_DONE, 6'd0, 48'hFFFF_FFFF_FFF8, 4'd0, '1, 1'b1));
		send_word(mk(CMD_RD_REQ, 6'd2, 48'h5, 4'd3, '0, 1'b1));
		// unaligned completion that still covers the range
		send_word(mk(CMD_RD_DONE, 6'd0, 48'h3, 4'd0, 64'hFEDC_BA98_7654_3210, 1'b0));
		send_word(mk(CMD_RD_REQ, 6'd3, 48'h7, 4'd0, '0, 1'b1));
		send_word(mk(CMD_RD_DONE, 6'd0, 48'h0, 4'd0, '1, 1'b1));
		send_word(mk(CMD_RD_REQ, 6'd4, 48'h0, 4'd9, '0, 1'b1));
		send_word(mk(CMD_WR_REQ, 6'd5, 48'h0, 4'd15, '1, 1'b1));
		send_word(mk(CMD_FL_REQ, 6'd6, 48'h6, 4'd4, '0, 1'b1));
		send_word(mk(CMD_RD_REQ, 6'd7, 48'h8, 4'd4, '0, 1'b0));
		send_word(mk(CMD_WR_REQ, 6'd8, 48'h8, 4'd4, '1, 1'b0));
		send_word(mk(CMD_WR_REQ, 6'd9, 48'h7, 4'd1, 64'hFFFF_FFFF_FFFF_FF5A, 1'b1));
		send_word(mk(CMD_WR_REQ, 6'd10, 48'hFFFF_FFFF_FFF8, 4'd8, '1, 1'b1));
		send_word(mk(CMD_WR_REQ, 6'd11, 48'h3, 4'd0, '1, 1'b1));
		// flush with writes pending, permission ignored: no word until drain
		send_word(mk(CMD_FL_REQ, 6'd12, 48'h0, 4'd0, '0, 1'b0));
		send_word(mk(CMD_RD_REQ, 6'd13, 48'h0, 4'd2, '0, 1'b1));
		send_word(mk(CMD_WR_REQ, 6'd14, 48'h2, 4'd5, 64'h1122_3344_5566_7788, 1'b1));
		repeat (5) send_word(mk(CMD_WR_DONE, 6'd0, 48'h0, 4'd0, '0, 1'b1));
		send_word(mk(CMD_FL_REQ, 6'd15, 48'h0, 4'd0, '0, 1'b1));
		for (int c = CMD_WR_DONE + 1; c <= CMD_TOP; c++) begin
			send_word(mk(CMD_W'(c), 6'd63, '1, 4'd15, '1, 1'b1));
		end
		wait_drained();
	endtask

	// Fill the write counter to its limit, hit busy, then drain with a flush waiting.
	task automatic test_write_limit();
		while (wr_pending != 0) send_word(mk(CMD_WR_DONE, 6'd0, 48'h0, 4'd0, '0, 1'b1));
		while (wr_pending < WR_LIMIT) begin
			send_word(mk(CMD_WR_REQ, CLIENT_W'($urandom_range(0, 63)),
				ADDR_W'({$urandom, $urandom}), 4'd1, {$urandom, $urandom}, 1'b1));
		end
		send_word(mk(CMD_WR_REQ, 6'd20, 48'h10, 4'd4, '1, 1'b1));
		send_word(mk(CMD_FL_REQ, 6'd21, 48'h0, 4'd0, '0, 1'b1));
		send_word(mk(CMD_RD_REQ, 6'd22, 48'h0, 4'd1, '0, 1'b1));
		while (wr_pending != 0) send_word(mk(CMD_WR_DONE, 6'd0, 48'h0, 4'd0, '0, 1'b1));
		wait_drained();
	endtask

	// Hold the output off for a long stretch while words keep coming, so the queue fills.
	task automatic test_output_hold();
		bus_word_t w;
		gaps_on = 1'b0;
		hold_left = 60;
		repeat (12) begin
			w = rand_word();
			w.cmd = CMD_WR_REQ;
			w.perm = 1'b1;
			w.size = SIZE_W'($urandom_range(0, LINE_BYTES - int'(w.addr % LINE_BYTES)));
			send_word(w);
		end
		repeat (12) send_word(rand_word());
		gaps_on = 1'b1;
		wait_drained();
	endtask

	task automatic test_random_traffic();
		for (int i = 0; i < 80; i++) begin
			if (i % 20 == 0) begin
				gaps_on = ($urandom_range(0, 3) != 0);
			end
			if (i % 40 == 20) begin
				wait_drained();
			end
			send_word(rand_word());
		end
		gaps_on = 1'b1;
		wait_drained();
	endtask

	initial begin
		rd_busy = 1'b0;
		wait_client = '0;
		wait_addr = '0;
		wait_size = '0;
		wr_pending = 0;
		fl_on = 1'b0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_write_limit();
		test_output_hold();
		test_random_traffic();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
